### rtl/mcs_pkg.sv
// shared types and constants of the macd crossover signal block
package mcs_pkg;

  // fixed point layout
  localparam int FRAC_BITS = 24;
  localparam int ALPHA_W   = FRAC_BITS + 1;
  localparam int OUT_W     = 33;
  localparam int SPAN_W    = 7;
  localparam int CNT_W     = 7;
  localparam int ACT_W     = 2;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] RUN_MAX = 7'd127;

  // register reset values
  localparam logic [SPAN_W-1:0] SHORT_SPAN_RST   = 7'd12;
  localparam logic [SPAN_W-1:0] LONG_SPAN_RST    = 7'd26;
  localparam logic [SPAN_W-1:0] SIGNAL_SPAN_RST  = 7'd9;
  localparam logic [SPAN_W-1:0] CONFIRM_LEN_RST  = 7'd50;

  typedef enum logic [1:0] {
    REG_SHORT_SPAN,
    REG_LONG_SPAN,
    REG_SIGNAL_SPAN,
    REG_CONFIRM_LEN
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_MACD,
    ST_DECIDE
  } state_t;

  // which average the shared unit works on
  typedef enum logic [1:0] {
    SEL_FAST,
    SEL_SLOW,
    SEL_SIG
  } avg_sel_t;

  typedef struct packed {
    logic [SPAN_W-1:0] short_span;
    logic [SPAN_W-1:0] long_span;
    logic [SPAN_W-1:0] signal_span;
    logic [SPAN_W-1:0] confirm_length;
  } cfg_t;

endpackage

### rtl/mcs_if.sv
// stream interfaces for the price input and the crossover result
interface mcs_in_if #(
  parameter int PRICE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface mcs_out_if;
  logic                                      valid;
  logic                                      ready;
  logic [mcs_pkg::ACT_W-1:0]                 action;
  logic signed [mcs_pkg::OUT_W-1:0]          macd_value;
  logic signed [mcs_pkg::OUT_W-1:0]          signal_value;

  modport source (output valid, output action, output macd_value, output signal_value,
                  input ready);
  modport sink   (input valid, input action, input macd_value, input signal_value,
                  output ready);
endinterface

### rtl/mcs_cfg.sv
// apb register file holding the spans and the confirm length
module mcs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcs_pkg::DATA_W-1:0]  pwdata,
  output logic [mcs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mcs_pkg::cfg_t               cfg
);

  mcs_pkg::cfg_t     cfg_r;
  mcs_pkg::reg_idx_t idx;
  logic              wr_en;
  logic [mcs_pkg::SPAN_W-1:0] wval;
  logic [mcs_pkg::SPAN_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = mcs_pkg::reg_idx_t'(paddr[mcs_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[mcs_pkg::SPAN_W-1:0];
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_span     <= mcs_pkg::SHORT_SPAN_RST;
      cfg_r.long_span      <= mcs_pkg::LONG_SPAN_RST;
      cfg_r.signal_span    <= mcs_pkg::SIGNAL_SPAN_RST;
      cfg_r.confirm_length <= mcs_pkg::CONFIRM_LEN_RST;
    end else if (wr_en) begin
      unique case (idx)
        mcs_pkg::REG_SHORT_SPAN:  cfg_r.short_span     <= wval;
        mcs_pkg::REG_LONG_SPAN:   cfg_r.long_span      <= wval;
        mcs_pkg::REG_SIGNAL_SPAN: cfg_r.signal_span    <= wval;
        mcs_pkg::REG_CONFIRM_LEN: cfg_r.confirm_length <= wval;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      mcs_pkg::REG_SHORT_SPAN:  rval = cfg_r.short_span;
      mcs_pkg::REG_LONG_SPAN:   rval = cfg_r.long_span;
      mcs_pkg::REG_SIGNAL_SPAN: rval = cfg_r.signal_span;
      mcs_pkg::REG_CONFIRM_LEN: rval = cfg_r.confirm_length;
      default:                  rval = '0;
    endcase
  end

  assign prdata = mcs_pkg::DATA_W'(rval);

endmodule

### rtl/mcs_mul.sv
// shared unsigned multiplier with registered product
module mcs_mul #(
  parameter int A_W = 24
) (
  input  logic                                clk,
  input  logic [A_W-1:0]                      a,
  input  logic [mcs_pkg::ALPHA_W-1:0]         b,
  output logic [A_W+mcs_pkg::ALPHA_W-1:0]     p_r
);

  localparam int P_W = A_W + mcs_pkg::ALPHA_W;

  // one partial product per cycle
  always_ff @(posedge clk) begin
    p_r <= P_W'(a) * P_W'(b);
  end

endmodule

### rtl/macd_crossover_signal.sv
// macd crossover detector: top level with sequencer and average datapath
//
// Usage: one price sample (unsigned Q16.16) enters per transaction on in_ch;
// each one yields exactly one result on out_ch carrying the action (none, buy,
// sell), the current MACD and the signal line, both signed Q16.16, saturated.
// The spans and the confirm length are set through the APB port (psel ...
// pready) at byte addresses 0, 4, 8 and 12; pready is always high.
// The three exponential averages are updated one after the other through a
// single 24 x 25-bit multiplier: per average a difference step, a low and a
// high partial product step and an accumulate step, with a MACD step before
// the signal average and a decision step at the end; in_ch.ready rises
// together with out_ch.valid, so a new sample is accepted only after the
// previous result has been loaded into the output register.
// The result sits in an output register; while it waits, the next sample is
// accepted and processed, and the sequencer holds in its decision step only
// when a second result is ready before the first was taken.
// Synchronous active-low reset restores the register defaults, clears the
// averages, the sample count and both run counters, and drops out_ch.valid.
module macd_crossover_signal #(
  parameter int PRICE_WIDTH = 32,
  parameter int MAX_SPAN    = 127
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mcs_in_if.sink                      in_ch,
  mcs_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcs_pkg::DATA_W-1:0]  pwdata,
  output logic [mcs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int FRAC  = mcs_pkg::FRAC_BITS;
  localparam int AW    = mcs_pkg::ALPHA_W;
  localparam int OW    = mcs_pkg::OUT_W;
  localparam int AVG_W = PRICE_WIDTH + 9;
  localparam int D_W   = AVG_W + 1;
  localparam int M_W   = AVG_W;
  localparam int HI_W  = M_W - FRAC;
  localparam int MA_W  = (HI_W > FRAC) ? HI_W : FRAC;
  localparam int P_W   = MA_W + AW;
  localparam int C_W   = P_W + 1 - FRAC;
  localparam int N_W   = $clog2(MAX_SPAN + 1);
  localparam int R_W   = AVG_W - 7;
  localparam int SAT_W = (R_W > OW + 1) ? R_W : OW + 1;
  localparam int SPAN_W = mcs_pkg::SPAN_W;
  localparam int CNT_W  = mcs_pkg::CNT_W;

  localparam logic signed [SAT_W-1:0] OUT_HI = SAT_W'((longint'(1) <<< (OW - 1)) - 1);
  localparam logic signed [SAT_W-1:0] OUT_LO = SAT_W'(-(longint'(1) <<< (OW - 1)));
  localparam logic [7:0] SPAN_CAP = 8'(MAX_SPAN);

  mcs_pkg::cfg_t     cfg;
  mcs_pkg::state_t   state_r, state_nxt;
  mcs_pkg::avg_sel_t sel_r, sel_nxt;

  logic [PRICE_WIDTH-1:0]  price_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        above_r, above_nxt;
  logic [CNT_W-1:0]        below_r, below_nxt;
  logic signed [AVG_W-1:0] fast_r, slow_r, sig_r, macd_r, macd_nxt;
  logic [M_W-1:0]          m_r;
  logic                    neg_r;
  logic [AW-1:0]           alpha_r;
  logic [C_W-1:0]          carry_r, carry_nxt;

  logic                    out_valid_r;
  mcs_pkg::action_t        action_r, action_nxt;
  logic signed [OW-1:0]    macd_out_r, sig_out_r;

  logic                    in_fire;
  logic                    out_load;
  logic signed [AVG_W-1:0] x_cur, avg_cur, avg_new;
  logic signed [D_W-1:0]   d, d_abs, step;
  logic [SPAN_W-1:0]       span_cur;
  logic [7:0]              span_c, cnt_inc, n_sel;
  logic [AW-1:0]           alpha_tab [MAX_SPAN+1];
  logic [MA_W-1:0]         mul_a;
  logic [P_W-1:0]          mul_p;
  logic [P_W:0]            rnd_sum, q;
  logic                    gt, lt;

  mcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // smoothing factor table: round(2^25 / (n + 1)) for n = 1 .. MAX_SPAN
  for (genvar g = 0; g <= MAX_SPAN; g++) begin : g_alpha
    localparam int Den   = g + 1;
    localparam int Alpha = ((1 << (FRAC + 1)) + Den / 2) / Den;
    assign alpha_tab[g] = AW'(Alpha);
  end

  // shared multiplier: low digit then high digit of the magnitude
  assign mul_a = (state_r == mcs_pkg::ST_MUL_LO) ? MA_W'(m_r[FRAC-1:0])
                                                 : MA_W'(m_r[M_W-1:FRAC]);

  mcs_mul #(.A_W(MA_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (alpha_r),
    .p_r (mul_p)
  );

  assign in_ch.ready = (state_r == mcs_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == mcs_pkg::ST_DECIDE) && (!out_valid_r || out_ch.ready);

  // operand and average selection
  always_comb begin
    unique case (sel_r)
      mcs_pkg::SEL_FAST: begin
        x_cur    = $signed({1'b0, price_r, 8'b0});
        avg_cur  = fast_r;
        span_cur = cfg.short_span;
      end
      mcs_pkg::SEL_SLOW: begin
        x_cur    = $signed({1'b0, price_r, 8'b0});
        avg_cur  = slow_r;
        span_cur = cfg.long_span;
      end
      default: begin
        x_cur    = macd_r;
        avg_cur  = sig_r;
        span_cur = cfg.signal_span;
      end
    endcase
  end

  // difference and its magnitude
  assign d     = D_W'(x_cur) - D_W'(avg_cur);
  assign d_abs = d[D_W-1] ? -d : d;

  // warm-up count limited by the clamped span
  always_comb begin
    span_c = {1'b0, span_cur};
    if (span_c == 8'd0) begin
      span_c = 8'd1;
    end else if (span_c > SPAN_CAP) begin
      span_c = SPAN_CAP;
    end
    cnt_inc = {1'b0, count_r} + 8'd1;
    n_sel   = (cnt_inc < span_c) ? cnt_inc : span_c;
  end

  // rounding carry from the low partial product
  assign rnd_sum   = {1'b0, mul_p} + (P_W+1)'(1 << (FRAC - 1));
  assign carry_nxt = rnd_sum[P_W:FRAC];

  // accumulate the rounded scaled step
  assign q       = {1'b0, mul_p} + (P_W+1)'(carry_r);
  assign step    = neg_r ? -D_W'(q) : D_W'(q);
  assign avg_new = AVG_W'(D_W'(avg_cur) + step);

  // macd, masked until the long span has passed
  assign macd_nxt = (count_r >= cfg.long_span) ? AVG_W'(fast_r - slow_r) : '0;

  // crossover runs and decision
  assign gt = macd_r > sig_r;
  assign lt = macd_r < sig_r;

  always_comb begin
    above_nxt = '0;
    below_nxt = '0;
    if (gt) begin
      above_nxt = (above_r == mcs_pkg::RUN_MAX) ? above_r : above_r + 1'b1;
    end else if (lt) begin
      below_nxt = (below_r == mcs_pkg::RUN_MAX) ? below_r : below_r + 1'b1;
    end
    count_nxt = (count_r == mcs_pkg::RUN_MAX) ? count_r : count_r + 1'b1;
    priority if (above_nxt >= cfg.confirm_length) begin
      action_nxt = mcs_pkg::ACT_BUY;
    end else if (below_nxt >= cfg.confirm_length) begin
      action_nxt = mcs_pkg::ACT_SELL;
    end else begin
      action_nxt = mcs_pkg::ACT_NONE;
    end
  end

  // round to 16 fractional bits half up, saturate to the output range
  function automatic logic [OW-1:0] to_q16(input logic signed [AVG_W-1:0] v);
    logic signed [AVG_W:0]   t;
    logic signed [SAT_W-1:0] r;
    logic signed [SAT_W-1:0] c;
    t = (AVG_W+1)'(v) + (AVG_W+1)'(128);
    r = SAT_W'(t >>> 8);
    if (r > OUT_HI) begin
      c = OUT_HI;
    end else if (r < OUT_LO) begin
      c = OUT_LO;
    end else begin
      c = r;
    end
    return c[OW-1:0];
  endfunction

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      mcs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = mcs_pkg::ST_DIFF;
          sel_nxt   = mcs_pkg::SEL_FAST;
        end
      end
      mcs_pkg::ST_DIFF:   state_nxt = mcs_pkg::ST_MUL_LO;
      mcs_pkg::ST_MUL_LO: state_nxt = mcs_pkg::ST_MUL_HI;
      mcs_pkg::ST_MUL_HI: state_nxt = mcs_pkg::ST_ACC;
      mcs_pkg::ST_ACC: begin
        unique case (sel_r)
          mcs_pkg::SEL_FAST: begin
            state_nxt = mcs_pkg::ST_DIFF;
            sel_nxt   = mcs_pkg::SEL_SLOW;
          end
          mcs_pkg::SEL_SLOW: state_nxt = mcs_pkg::ST_MACD;
          default:           state_nxt = mcs_pkg::ST_DECIDE;
        endcase
      end
      mcs_pkg::ST_MACD: begin
        state_nxt = mcs_pkg::ST_DIFF;
        sel_nxt   = mcs_pkg::SEL_SIG;
      end
      mcs_pkg::ST_DECIDE: begin
        if (out_load) begin
          state_nxt = mcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcs_pkg::ST_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcs_pkg::ST_IDLE;
      sel_r   <= mcs_pkg::SEL_FAST;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // block state: averages, sample count, runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r  <= '0;
      slow_r  <= '0;
      sig_r   <= '0;
      count_r <= '0;
      above_r <= '0;
      below_r <= '0;
    end else begin
      if (state_r == mcs_pkg::ST_ACC) begin
        unique case (sel_r)
          mcs_pkg::SEL_FAST: fast_r <= avg_new;
          mcs_pkg::SEL_SLOW: slow_r <= avg_new;
          default:           sig_r  <= avg_new;
        endcase
      end
      if (out_load) begin
        count_r <= count_nxt;
        above_r <= above_nxt;
        below_r <= below_nxt;
      end
    end
  end

  // working registers of the shared unit
  always_ff @(posedge clk) begin
    if (in_fire) begin
      price_r <= in_ch.price;
    end
    if (state_r == mcs_pkg::ST_DIFF) begin
      m_r     <= d_abs[M_W-1:0];
      neg_r   <= d[D_W-1];
      alpha_r <= alpha_tab[n_sel[N_W-1:0]];
    end
    if (state_r == mcs_pkg::ST_MUL_HI) begin
      carry_r <= carry_nxt;
    end
    if (state_r == mcs_pkg::ST_MACD) begin
      macd_r <= macd_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      action_r   <= action_nxt;
      macd_out_r <= to_q16(macd_r);
      sig_out_r  <= to_q16(sig_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = action_r;
  assign out_ch.macd_value   = macd_out_r;
  assign out_ch.signal_value = sig_out_r;

  // an accepted sample starts with the fast average
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == mcs_pkg::ST_DIFF) && (sel_r == mcs_pkg::SEL_FAST))
    else $error("sequencer did not start on the fast average");

  // a new result only comes out of the decision step
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == mcs_pkg::ST_DECIDE)
    else $error("result loaded outside the decision step");

  // the two runs never count at the same time
  a_runs: assert property (@(posedge clk) disable iff (!rst_n)
    !((above_r != '0) && (below_r != '0)))
    else $error("above and below runs both nonzero");

  // a run cannot be longer than the samples seen
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (above_r <= count_r) && (below_r <= count_r))
    else $error("run longer than sample count");

  // smoothing factor within (0, 1] while multiplying
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcs_pkg::ST_MUL_LO) |-> (alpha_r != '0) && (alpha_r <= AW'(1 << FRAC)))
    else $error("smoothing factor out of range");

endmodule

### dv/testbench.sv
// self-checking testbench for the macd crossover signal block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SPAN      = 127;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 300;
  localparam longint OUT_TOP   = 64'sh0000_0000_FFFF_FFFF;
  localparam longint OUT_BOT   = -64'sh0000_0001_0000_0000;
  localparam longint PRICE_TOP = 64'sh0000_0000_FFFF_FFFF;

  // kinds of market movement used by the random stimulus
  typedef enum int {
    MOVE_TREND,
    MOVE_FLAT,
    MOVE_WILD,
    MOVE_JUMP
  } move_t;

  // one expected result transaction
  typedef struct {
    mcs_pkg::action_t   action;
    logic signed [32:0] macd;
    logic signed [32:0] sig;
  } crossover_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mcs_pkg::ADDR_W-1:0] paddr;
  logic [mcs_pkg::DATA_W-1:0] pwdata;
  logic [mcs_pkg::DATA_W-1:0] prdata;
  logic pready;

  mcs_in_if #(.PRICE_WIDTH(32)) in_ch ();
  mcs_out_if out_ch ();

  macd_crossover_signal #(
    .PRICE_WIDTH(32),
    .MAX_SPAN   (MAX_SPAN)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state and register mirror
  mcs_pkg::cfg_t cfg_mirror;
  longint      fast_avg;
  longint      slow_avg;
  longint      sig_avg;
  int unsigned samples_seen;
  int unsigned rise_run;
  int unsigned fall_run;

  crossover_t  pending_signals[$];
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned prices_sent;
  int unsigned buy_count;
  int unsigned sell_count;
  int unsigned input_stall_cycles;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  int unsigned hold_request;
  bit          steady;
  longint      market_level;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // smoothing factor 2/(n+1) with 24 fraction bits, n limited by the clamped span
  function automatic longint unsigned smoothing_factor(int unsigned span, int unsigned count);
    longint unsigned s;
    longint unsigned n;
    s = span;
    if (s < 1) s = 1;
    if (s > MAX_SPAN) s = MAX_SPAN;
    n = count + 1;
    if (n > s) n = s;
    return ((64'd1 << (mcs_pkg::FRAC_BITS + 1)) + (n + 1) / 2) / (n + 1);
  endfunction

  // avg += alpha * (x - avg), product rounded half away from zero
  function automatic longint ema_step(longint avg, longint x, int unsigned span,
                                      int unsigned count);
    longint d;
    longint unsigned a;
    longint unsigned m;
    longint unsigned q;
    d = x - avg;
    a = smoothing_factor(span, count);
    m = (d < 0) ? longint'(-d) : longint'(d);
    q = (m >> mcs_pkg::FRAC_BITS) * a +
        (((m & ((64'd1 << mcs_pkg::FRAC_BITS) - 1)) * a +
          (64'd1 << (mcs_pkg::FRAC_BITS - 1))) >> mcs_pkg::FRAC_BITS);
    return (d < 0) ? avg - longint'(q) : avg + longint'(q);
  endfunction

  // 24 fraction bits down to 16, half up, saturated to 33 bits
  function automatic logic signed [32:0] to_q16(longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > OUT_TOP) r = OUT_TOP;
    if (r < OUT_BOT) r = OUT_BOT;
    return r[32:0];
  endfunction

  // advance the predictor by one price sample
  function automatic crossover_t predict_crossover(logic [31:0] price);
    crossover_t res;
    longint x;
    longint macd;
    x = longint'(price) * 256;
    macd = 0;
    fast_avg = ema_step(fast_avg, x, cfg_mirror.short_span, samples_seen);
    slow_avg = ema_step(slow_avg, x, cfg_mirror.long_span, samples_seen);
    if (samples_seen >= cfg_mirror.long_span) macd = fast_avg - slow_avg;
    sig_avg = ema_step(sig_avg, macd, cfg_mirror.signal_span, samples_seen);
    if (macd > sig_avg) begin
      if (rise_run < mcs_pkg::RUN_MAX) rise_run++;
      fall_run = 0;
    end else if (macd < sig_avg) begin
      if (fall_run < mcs_pkg::RUN_MAX) fall_run++;
      rise_run = 0;
    end else begin
      rise_run = 0;
      fall_run = 0;
    end
    if (samples_seen < mcs_pkg::RUN_MAX) samples_seen++;
    if (rise_run >= cfg_mirror.confirm_length) res.action = mcs_pkg::ACT_BUY;
    else if (fall_run >= cfg_mirror.confirm_length) res.action = mcs_pkg::ACT_SELL;
    else res.action = mcs_pkg::ACT_NONE;
    res.macd = to_q16(macd);
    res.sig = to_q16(sig_avg);
    return res;
  endfunction

  // result check first, then prediction of the accepted price
  always @(posedge clk) begin
    crossover_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_signals.size() == 0) begin
        $display("%0t: result with no expectation, action %0d macd %0d signal %0d",
                 $time, out_ch.action, out_ch.macd_value, out_ch.signal_value);
        fail_count++;
      end else begin
        want = pending_signals.pop_front();
        if (want.action == mcs_pkg::ACT_BUY) buy_count++;
        if (want.action == mcs_pkg::ACT_SELL) sell_count++;
        if (out_ch.action !== want.action) begin
          $display("%0t: action mismatch, expected %0d actual %0d",
                   $time, want.action, out_ch.action);
          fail_count++;
        end
        if (out_ch.macd_value !== want.macd) begin
          $display("%0t: macd mismatch, expected %0d actual %0d",
                   $time, want.macd, out_ch.macd_value);
          fail_count++;
        end
        if (out_ch.signal_value !== want.sig) begin
          $display("%0t: signal mismatch, expected %0d actual %0d",
                   $time, want.sig, out_ch.signal_value);
          fail_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_signals.push_back(predict_crossover(in_ch.price));
    end
    if (rst_n && in_ch.valid && !in_ch.ready) input_stall_cycles++;
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_signals.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // result receiver with random stalls and an on-demand long hold-off
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // send one price sample after a random gap
  task automatic send_price(logic [31:0] price);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.price <= price;
    do @(posedge clk); while (!in_ch.ready);
    prices_sent++;
  endtask

  // lower valid and wait until every expected result has come
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_signals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one apb transfer: setup then access
  task automatic apb_transfer(bit is_write, mcs_pkg::reg_idx_t idx,
                              logic [mcs_pkg::SPAN_W-1:0] value,
                              output logic [mcs_pkg::DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= mcs_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(mcs_pkg::reg_idx_t idx, logic [mcs_pkg::SPAN_W-1:0] want);
    logic [mcs_pkg::DATA_W-1:0] got;
    apb_transfer(1'b0, idx, '0, got);
    if (got !== mcs_pkg::DATA_W'(want)) begin
      $display("%0t: register %s readback, expected %0d actual %0d",
               $time, idx.name(), want, got);
      fail_count++;
    end
  endtask

  // write a register, mirror it and read it back
  task automatic set_register(mcs_pkg::reg_idx_t idx, logic [mcs_pkg::SPAN_W-1:0] value);
    logic [mcs_pkg::DATA_W-1:0] unused;
    apb_transfer(1'b1, idx, value, unused);
    case (idx)
      mcs_pkg::REG_SHORT_SPAN:  cfg_mirror.short_span = value;
      mcs_pkg::REG_LONG_SPAN:   cfg_mirror.long_span = value;
      mcs_pkg::REG_SIGNAL_SPAN: cfg_mirror.signal_span = value;
      default:                  cfg_mirror.confirm_length = value;
    endcase
    check_register(idx, value);
  endtask

  task automatic apply_setting(logic [mcs_pkg::SPAN_W-1:0] fast_span,
                               logic [mcs_pkg::SPAN_W-1:0] slow_span,
                               logic [mcs_pkg::SPAN_W-1:0] sig_span,
                               logic [mcs_pkg::SPAN_W-1:0] confirm);
    drain_results();
    set_register(mcs_pkg::REG_SHORT_SPAN, fast_span);
    set_register(mcs_pkg::REG_LONG_SPAN, slow_span);
    set_register(mcs_pkg::REG_SIGNAL_SPAN, sig_span);
    set_register(mcs_pkg::REG_CONFIRM_LEN, confirm);
    settings_used++;
  endtask

  // price stream built from trends, flats, wild noise and jumps
  task automatic send_market(int unsigned n_items);
    int unsigned left;
    int unsigned seg;
    move_t mode;
    longint slope;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(5, 40);
      if (seg > left) seg = left;
      case ($urandom_range(0, 9))
        0:       mode = MOVE_FLAT;
        1:       mode = MOVE_WILD;
        2:       mode = MOVE_JUMP;
        default: mode = MOVE_TREND;
      endcase
      slope = longint'($urandom_range(0, 32'h0010_0000));
      if ($urandom_range(0, 1)) slope = -slope;
      repeat (seg) begin
        case (mode)
          MOVE_TREND: market_level += slope + longint'($urandom_range(0, 4095)) - 2048;
          MOVE_WILD:  market_level = longint'($urandom);
          MOVE_JUMP:  market_level += slope * 256;
          default:    ;
        endcase
        if (market_level < 0) market_level = 0;
        if (market_level > PRICE_TOP) market_level = PRICE_TOP;
        send_price(market_level[31:0]);
      end
      left -= seg;
    end
  endtask

  // reset values read back
  task automatic test_register_defaults();
    check_register(mcs_pkg::REG_SHORT_SPAN, mcs_pkg::SHORT_SPAN_RST);
    check_register(mcs_pkg::REG_LONG_SPAN, mcs_pkg::LONG_SPAN_RST);
    check_register(mcs_pkg::REG_SIGNAL_SPAN, mcs_pkg::SIGNAL_SPAN_RST);
    check_register(mcs_pkg::REG_CONFIRM_LEN, mcs_pkg::CONFIRM_LEN_RST);
  endtask

  // short spans: warm-up, early masking, equal lines, price extremes, ramps
  task automatic test_directed_warmup();
    apply_setting(7'd2, 7'd4, 7'd3, 7'd3);
    send_price(32'h0000_0000);
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0001);
    send_price(32'h8000_0000);
    send_price(32'h7FFF_FFFF);
    for (int i = 1; i <= 10; i++) send_price(32'h0010_0000 * i);
    for (int i = 8; i >= 1; i--) send_price(32'h0008_0000 * i);
  endtask

  // zero and largest spans and confirm lengths
  task automatic test_span_extremes();
    apply_setting(7'd0, 7'd0, 7'd0, 7'd0);
    send_market(30);
    apply_setting(7'd127, 7'd127, 7'd127, 7'd127);
    send_market(30);
    apply_setting(7'd1, 7'd127, 7'd1, 7'd1);
    send_market(30);
    apply_setting(7'd127, 7'd1, 7'd127, 7'd0);
    send_market(30);
    apply_setting(7'd1, 7'd0, 7'd127, 7'd2);
    send_market(30);
  endtask

  // runs built under a long confirm length are judged by a shorter one later
  task automatic test_confirm_change();
    apply_setting(7'd3, 7'd10, 7'd4, 7'd127);
    market_level = 64'h0100_0000;
    for (int i = 0; i < 40; i++) begin
      market_level += 64'h0004_0000 * (i + 1);
      send_price(market_level[31:0]);
    end
    drain_results();
    set_register(mcs_pkg::REG_CONFIRM_LEN, 7'd1);
    send_market(20);
  endtask

  // receiver holds off while the sender keeps offering samples
  task automatic test_backpressure();
    apply_setting(7'd5, 7'd12, 7'd4, 7'd2);
    steady = 1'b1;
    hold_request = LONG_HOLD;
    send_market(30);
    drain_results();
    steady = 1'b0;
  endtask

  // random settings with random market streams
  task automatic test_random_markets();
    logic [mcs_pkg::SPAN_W-1:0] fast_span;
    logic [mcs_pkg::SPAN_W-1:0] slow_span;
    for (int phase = 0; phase < 12; phase++) begin
      fast_span = mcs_pkg::SPAN_W'($urandom_range(1, 16));
      slow_span = fast_span + mcs_pkg::SPAN_W'($urandom_range(0, 30));
      if ($urandom_range(0, 3) == 0) begin
        apply_setting(mcs_pkg::SPAN_W'($urandom_range(0, 127)),
                      mcs_pkg::SPAN_W'($urandom_range(0, 127)),
                      mcs_pkg::SPAN_W'($urandom_range(0, 127)),
                      mcs_pkg::SPAN_W'($urandom_range(0, 127)));
      end else begin
        apply_setting(fast_span, slow_span, mcs_pkg::SPAN_W'($urandom_range(1, 12)),
                      mcs_pkg::SPAN_W'($urandom_range(1, 10)));
      end
      steady = (phase % 4 == 3);
      send_market(60);
    end
    steady = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.price  <= '0;
    cfg_mirror   = '{mcs_pkg::SHORT_SPAN_RST, mcs_pkg::LONG_SPAN_RST,
                     mcs_pkg::SIGNAL_SPAN_RST, mcs_pkg::CONFIRM_LEN_RST};
    fast_avg     = 0;
    slow_avg     = 0;
    sig_avg      = 0;
    samples_seen = 0;
    rise_run     = 0;
    fall_run     = 0;
    fail_count   = 0;
    results_checked = 0;
    prices_sent  = 0;
    buy_count    = 0;
    sell_count   = 0;
    input_stall_cycles = 0;
    settings_used = 0;
    quiet_cycles = 0;
    hold_request = 0;
    steady       = 1'b0;
    market_level = 64'h0080_0000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_directed_warmup();
    test_span_extremes();
    test_confirm_change();
    test_backpressure();
    test_random_markets();
    drain_results();

    $display("sent %0d price samples under %0d register settings, checked %0d results",
             prices_sent, settings_used, results_checked);
    $display("buy results %0d, sell results %0d, input stalled %0d cycles",
             buy_count, sell_count, input_stall_cycles);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/mcs_pkg.sv
rtl/mcs_if.sv
rtl/mcs_cfg.sv
rtl/mcs_mul.sv
rtl/macd_crossover_signal.sv
dv/testbench.sv
